>>> rtl/swa_pkg.sv
// Shared types and fixed constants of the sliding window average block.
`default_nettype none

package swa_pkg;

  // Width of the window width register and its value after reset
  localparam int WIDTH_REG_BITS = 7;
  localparam logic [WIDTH_REG_BITS-1:0] WIDTH_RESET = 7'd13;

  // Fixed-point format of the average
  localparam int FRAC_BITS = 16;
  localparam int AVG_BITS  = 32;

  // Register port geometry
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;

  // Register index, taken from the word address bit
  localparam logic [0:0] REG_WINDOW_WIDTH = 1'b0;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // latch the item, clear the series if asked
    logic rd_issue;  // read the ring entry that leaves the window
    logic update;    // write ring, update sum, slot and fill count
    logic div_start; // load the divider with the scaled sum
    logic load_out;  // move the finished result into the output register
  } swa_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_busy;
  } swa_sts_t;

endpackage

`default_nettype wire

>>> rtl/swa_regs.sv
// Configuration register file with its APB-style access port.
`default_nettype none

module swa_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [swa_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [swa_pkg::DATA_BITS-1:0]  pwdata,
  output logic [swa_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  output logic [swa_pkg::WIDTH_REG_BITS-1:0] window_width
);
  import swa_pkg::*;

  logic [0:0] reg_idx;
  logic       wr_en;

  // Word address picks the register; byte offset bits are ignored
  assign reg_idx = paddr[ADDR_BITS-1 -: 1];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_width <= WIDTH_RESET;
    end else if (wr_en && (reg_idx == REG_WINDOW_WIDTH)) begin
      window_width <= pwdata[WIDTH_REG_BITS-1:0];
    end
  end

  // Read back; unmapped addresses read as zero
  always_comb begin
    if (reg_idx == REG_WINDOW_WIDTH) begin
      prdata = DATA_BITS'(window_width);
    end else begin
      prdata = '0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/swa_div.sv
// Restoring divider, one quotient bit per cycle, signed dividend over a positive divisor.
`default_nettype none

module swa_div #(
  parameter int DVD_BITS = 38,
  parameter int DVS_BITS = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [DVD_BITS-1:0] dividend,
  input  logic [DVS_BITS-1:0]        divisor,
  output logic                       busy,
  output logic [DVD_BITS-1:0]        quot_mag,
  output logic                       quot_neg
);

  localparam int CNT_BITS = $clog2(DVD_BITS);

  logic [CNT_BITS-1:0] cnt;
  logic [DVD_BITS-1:0] quot;
  logic [DVS_BITS-1:0] rem;
  logic [DVS_BITS-1:0] dvs;
  logic                neg;
  logic [DVS_BITS:0]   shifted;
  logic [DVS_BITS:0]   diff;
  logic                fits;

  // Trial subtraction of one step
  assign shifted = {rem, quot[DVD_BITS-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = (shifted >= {1'b0, dvs});

  // Control: busy from start until a quotient bit has been shifted in for every dividend bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_BITS'(1);
      if (cnt == CNT_BITS'(DVD_BITS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: magnitude in, quotient shifts in from the right
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend[DVD_BITS-1] ? DVD_BITS'(-dividend) : DVD_BITS'(dividend);
      rem  <= '0;
      dvs  <= divisor;
      neg  <= dividend[DVD_BITS-1];
    end else if (busy) begin
      quot <= {quot[DVD_BITS-2:0], fits};
      rem  <= fits ? diff[DVS_BITS-1:0] : shifted[DVS_BITS-1:0];
    end
  end

  assign quot_mag = quot;
  assign quot_neg = neg;

  // A started division is running on the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy)
    else $error("divider not busy after start");

  // Partial remainder always stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rem < dvs))
    else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

>>> rtl/swa_datapath.sv
// Datapath: sample ring, running sum, fill tracking, divider and output register.
`default_nettype none

module swa_datapath #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  swa_pkg::swa_cmd_t                    cmd,
  output swa_pkg::swa_sts_t                    sts,
  input  logic [swa_pkg::WIDTH_REG_BITS-1:0]   window_width,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  input  logic                                 start_series,
  output logic signed [swa_pkg::AVG_BITS-1:0]  average,
  output logic                                 window_full
);
  import swa_pkg::*;

  localparam int PTR_BITS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_BITS = $clog2(WINDOW_MAX + 1);
  localparam int IDX_BITS = CNT_BITS + 1;
  localparam int SUM_BITS = SAMPLE_BITS + PTR_BITS;
  localparam int DVD_BITS = SUM_BITS + FRAC_BITS;

  // Ring memory, no reset: an entry's value is used only after this series wrote it
  logic signed [SAMPLE_BITS-1:0] ring [WINDOW_MAX];

  logic signed [SAMPLE_BITS-1:0] smp;
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic [CNT_BITS-1:0]           w_eff;
  logic [PTR_BITS-1:0]           write_slot;
  logic [CNT_BITS-1:0]           fill_count;
  logic signed [SUM_BITS-1:0]    run_sum;
  logic                          full;

  logic [31:0]                   width_ext;
  logic [CNT_BITS-1:0]           w_clamped;
  logic [IDX_BITS-1:0]           slot_ext;
  logic [IDX_BITS-1:0]           w_ext;
  logic [PTR_BITS-1:0]           old_idx;
  logic signed [SAMPLE_BITS-1:0] drop;
  logic signed [SUM_BITS-1:0]    run_sum_next;
  logic [CNT_BITS-1:0]           fill_count_next;
  logic [PTR_BITS-1:0]           write_slot_next;
  logic                          full_next;
  logic signed [DVD_BITS-1:0]    dividend;
  logic                          div_busy;
  logic [DVD_BITS-1:0]           quot_mag;
  logic                          quot_neg;
  logic [63:0]                   mag_ext;
  logic signed [AVG_BITS-1:0]    avg_sat;

  // Clamp the register to 1..WINDOW_MAX
  assign width_ext = 32'(window_width);
  always_comb begin
    if (width_ext == 32'd0) begin
      w_clamped = CNT_BITS'(1);
    end else if (width_ext > 32'(WINDOW_MAX)) begin
      w_clamped = CNT_BITS'(WINDOW_MAX);
    end else begin
      w_clamped = CNT_BITS'(width_ext);
    end
  end

  // Slot of the sample leaving the window, w_eff slots behind write_slot
  assign slot_ext = IDX_BITS'(write_slot);
  assign w_ext    = IDX_BITS'(w_eff);
  always_comb begin
    if (slot_ext >= w_ext) begin
      old_idx = PTR_BITS'(slot_ext - w_ext);
    end else begin
      old_idx = PTR_BITS'(slot_ext + IDX_BITS'(WINDOW_MAX) - w_ext);
    end
  end

  // Series update
  assign drop         = (fill_count >= w_eff) ? rd_data : '0;
  assign run_sum_next = run_sum + SUM_BITS'(smp) - SUM_BITS'(drop);

  always_comb begin
    if (fill_count < CNT_BITS'(WINDOW_MAX)) begin
      fill_count_next = fill_count + CNT_BITS'(1);
    end else begin
      fill_count_next = fill_count;
    end
  end

  always_comb begin
    if (write_slot == PTR_BITS'(WINDOW_MAX - 1)) begin
      write_slot_next = '0;
    end else begin
      write_slot_next = write_slot + PTR_BITS'(1);
    end
  end

  assign full_next = (fill_count_next >= w_eff);

  // Series state: cleared by reset and by a series start
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
      run_sum    <= '0;
    end else if (cmd.capture && start_series) begin
      write_slot <= '0;
      fill_count <= '0;
      run_sum    <= '0;
    end else if (cmd.update) begin
      write_slot <= write_slot_next;
      fill_count <= fill_count_next;
      run_sum    <= run_sum_next;
    end
  end

  // Item payload and window flag
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      smp   <= sample;
      w_eff <= w_clamped;
    end
    if (cmd.update) begin
      full <= full_next;
    end
  end

  // Ring write port
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      ring[write_slot] <= smp;
    end
  end

  // Ring read port, registered
  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data <= ring[old_idx];
    end
  end

  // Scaled sum over the window width
  assign dividend = {run_sum, {FRAC_BITS{1'b0}}};

  swa_div #(
    .DVD_BITS (DVD_BITS),
    .DVS_BITS (CNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (w_eff),
    .busy     (div_busy),
    .quot_mag (quot_mag),
    .quot_neg (quot_neg)
  );

  assign sts.div_busy = div_busy;

  // Apply sign and saturate to the 32-bit range
  assign mag_ext = 64'(quot_mag);
  always_comb begin
    if (quot_neg) begin
      if (mag_ext > 64'h0000_0000_8000_0000) begin
        avg_sat = 32'sh8000_0000;
      end else begin
        avg_sat = -$signed(mag_ext[31:0]);
      end
    end else begin
      if (mag_ext > 64'h0000_0000_7FFF_FFFF) begin
        avg_sat = 32'sh7FFF_FFFF;
      end else begin
        avg_sat = $signed(mag_ext[31:0]);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      average     <= full ? avg_sat : '0;
      window_full <= full;
    end
  end

endmodule

`default_nettype wire

>>> rtl/swa_ctrl.sv
// Controller: sequences one item through the datapath and owns the output handshake.
`default_nettype none

module swa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output swa_pkg::swa_cmd_t cmd,
  input  swa_pkg::swa_sts_t sts
);
  import swa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_DSTART,
    S_DIV,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // State and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // wait until the output register is free or being emptied
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // At most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  // A result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("output register overwritten");

endmodule

`default_nettype wire

>>> rtl/sliding_window_average.sv
// Sliding window average: top level joining register port, controller and datapath.
//
// Each accepted item yields exactly one result: the mean of the last window_width samples
// (clamped to 1..WINDOW_MAX) in signed fixed point with 16 fraction bits, truncated toward
// zero, or zero with window_full low until the window has filled. An item passes, after
// acceptance, through ring read, sum update, divider load, the division by the restoring
// divider, which produces one quotient bit per cycle over the scaled sum, the end of the
// division and result load before the result is presented. Items are handled one at a
// time; the next item is taken as soon as the previous result is in the output register,
// even while that result waits to be taken. The sample ring is not cleared after reset:
// entries are only used once the current series has written them.
`default_nettype none

module sliding_window_average #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  input  logic                                 start_series,
  // result items
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [swa_pkg::AVG_BITS-1:0]  average,
  output logic                                 window_full,
  // register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [swa_pkg::ADDR_BITS-1:0]        paddr,
  input  logic [swa_pkg::DATA_BITS-1:0]        pwdata,
  output logic [swa_pkg::DATA_BITS-1:0]        prdata,
  output logic                                 pready
);
  import swa_pkg::*;

  logic [WIDTH_REG_BITS-1:0] window_width;
  swa_cmd_t                  cmd;
  swa_sts_t                  sts;

  swa_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .window_width (window_width)
  );

  swa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  swa_datapath #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .window_width (window_width),
    .sample       (sample),
    .start_series (start_series),
    .average      (average),
    .window_full  (window_full)
  );

endmodule

`default_nettype wire
